// File: rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and small arithmetic helpers of the look-at
// view matrix unit.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // bit length that the largest magnitude is scaled to before the root
  localparam int NORM_TOP      = 30;
  localparam int SQRT_STEPS    = 31;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [31:0] word_t;
  typedef logic [1:0]         col_t;

  localparam col_t COL_LAST = 2'd3;

  localparam wide_t SAT_HI = 64'sd2147483647;
  localparam wide_t SAT_LO = -64'sd2147483648;

  typedef struct packed {
    word_t [2:0] rgt;
    word_t [2:0] upv;
    word_t [2:0] negf;
    word_t [2:0] trn;
    logic        degen;
  } mat_t;

  function automatic logic [6:0] bitlen64(logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // shift right by frac, rounding half away from zero
  function automatic wide_t round_shift(wide_t v, int frac);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'(1) << (frac - 1))) >> frac;
    return v[63] ? -wide_t'(r) : wide_t'(r);
  endfunction

  function automatic word_t sat32(wide_t v);
    word_t res;
    if (v > SAT_HI) res = word_t'(SAT_HI[31:0]);
    else if (v < SAT_LO) res = word_t'(SAT_LO[31:0]);
    else res = word_t'(v[31:0]);
    return res;
  endfunction

endpackage

// File: rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale, sum of squares, bit-per-stage
// integer square root and bit-per-stage division in three lanes.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  lav_pkg::wide_t     vec_in [3],
  input  logic [SIDE_W-1:0]  side_in,
  output logic               out_valid,
  output lav_pkg::word_t     vec_out [3],
  output logic               zero_out,
  output logic [SIDE_W-1:0]  side_out
);
  import lav_pkg::*;

  localparam int QB = FRAC_BITS + 1;

  // stage 1: magnitudes and maximum
  logic              s1_v;
  logic [63:0]       s1_mag [3];
  logic [2:0]        s1_neg;
  logic [63:0]       s1_mx;
  logic [SIDE_W-1:0] s1_side;
  logic [63:0]       mag_c [3];
  logic [63:0]       mx_c;

  always_comb begin
    mx_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_in[i][63] ? 64'(-vec_in[i]) : 64'(vec_in[i]);
      if (mag_c[i] > mx_c) mx_c = mag_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag[i] <= mag_c[i];
        s1_neg[i] <= vec_in[i][63];
      end
      s1_mx   <= mx_c;
      s1_side <= side_in;
    end
  end

  // stage 2: bit length of the maximum
  logic              s2_v;
  logic [63:0]       s2_mag [3];
  logic [2:0]        s2_neg;
  logic [6:0]        s2_bl;
  logic              s2_zero;
  logic [SIDE_W-1:0] s2_side;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
    if (adv) begin
      s2_mag  <= s1_mag;
      s2_neg  <= s1_neg;
      s2_bl   <= bitlen64(s1_mx);
      s2_zero <= (s1_mx == '0);
      s2_side <= s1_side;
    end
  end

  // stage 3: common scaling shift
  logic              s3_v;
  logic [29:0]       s3_m [3];
  logic [2:0]        s3_neg;
  logic              s3_zero;
  logic [SIDE_W-1:0] s3_side;
  logic [29:0]       m_c [3];
  localparam logic [6:0] TOP7 = 7'(NORM_TOP);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_bl > TOP7) m_c[i] = 30'(s2_mag[i] >> (s2_bl - TOP7));
      else m_c[i] = 30'(s2_mag[i] << (TOP7 - s2_bl));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
    if (adv) begin
      s3_m    <= m_c;
      s3_neg  <= s2_neg;
      s3_zero <= s2_zero;
      s3_side <= s2_side;
    end
  end

  // stage 4: squares
  logic              s4_v;
  logic [59:0]       s4_sq [3];
  logic [29:0]       s4_m [3];
  logic [2:0]        s4_neg;
  logic              s4_zero;
  logic [SIDE_W-1:0] s4_side;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
    if (adv) begin
      for (int i = 0; i < 3; i++) s4_sq[i] <= 60'(s3_m[i]) * 60'(s3_m[i]);
      s4_m    <= s3_m;
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      s4_side <= s3_side;
    end
  end

  // root pipeline, index 0 holds the sum of squares
  logic              sq_v    [SQRT_STEPS+1];
  logic [62:0]       sq_rem  [SQRT_STEPS+1];
  logic [62:0]       sq_res  [SQRT_STEPS+1];
  logic [29:0]       sq_m    [SQRT_STEPS+1][3];
  logic [2:0]        sq_neg  [SQRT_STEPS+1];
  logic              sq_zero [SQRT_STEPS+1];
  logic [SIDE_W-1:0] sq_side [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= s4_v;
    if (adv) begin
      sq_rem[0]  <= 63'(s4_sq[0]) + 63'(s4_sq[1]) + 63'(s4_sq[2]);
      sq_res[0]  <= '0;
      sq_m[0]    <= s4_m;
      sq_neg[0]  <= s4_neg;
      sq_zero[0] <= s4_zero;
      sq_side[0] <= s4_side;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [62:0] trial;
    logic        ge;
    assign trial = sq_res[k] + BIT;
    assign ge    = (sq_rem[k] >= trial);
    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
      if (adv) begin
        sq_rem[k+1]  <= ge ? sq_rem[k] - trial : sq_rem[k];
        sq_res[k+1]  <= ge ? (sq_res[k] >> 1) + BIT : sq_res[k] >> 1;
        sq_m[k+1]    <= sq_m[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // division pipeline, index 0 holds the rounded dividends
  logic              dv_v    [QB+1];
  logic [63:0]       dv_rem  [QB+1][3];
  logic [QB-1:0]     dv_q    [QB+1][3];
  logic [31:0]       dv_len  [QB+1];
  logic [2:0]        dv_neg  [QB+1];
  logic              dv_zero [QB+1];
  logic [SIDE_W-1:0] dv_side [QB+1];
  logic [31:0]       len_c;

  assign len_c = sq_res[SQRT_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= sq_v[SQRT_STEPS];
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (64'(sq_m[SQRT_STEPS][i]) << FRAC_BITS) + 64'(len_c >> 1);
        dv_q[0][i]   <= '0;
      end
      dv_len[0]  <= len_c;
      dv_neg[0]  <= sq_neg[SQRT_STEPS];
      dv_zero[0] <= sq_zero[SQRT_STEPS];
      dv_side[0] <= sq_side[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [63:0] sub;
    logic [2:0]  ge;
    assign sub = 64'(dv_len[j]) << SH;
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = (dv_rem[j][i] >= sub);
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (adv) dv_v[j+1] <= dv_v[j];
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? dv_rem[j][i] - sub : dv_rem[j][i];
          dv_q[j+1][i]   <= QB'({dv_q[j][i], ge[i]});
        end
        dv_len[j+1]  <= dv_len[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // output stage: restore signs, force zero vector
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_v[QB];
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero[QB]) vec_out[i] <= '0;
        else if (dv_neg[QB][i]) vec_out[i] <= -word_t'(32'(dv_q[QB][i]));
        else vec_out[i] <= word_t'(32'(dv_q[QB][i]));
      end
      zero_out <= dv_zero[QB];
      side_out <= dv_side[QB];
    end
  end

endmodule

// File: rtl/lav_out.sv
// ----------------------------------------------------------------------------
// lav_out
// Output register: holds one finished matrix and sends it as four
// column transfers.
// ----------------------------------------------------------------------------
module lav_out #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load_valid,
  input  lav_pkg::mat_t  mat,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output lav_pkg::col_t  column,
  output lav_pkg::word_t elem_x,
  output lav_pkg::word_t elem_y,
  output lav_pkg::word_t elem_z,
  output lav_pkg::word_t elem_w,
  output logic           last_column,
  output logic           degenerate
);
  import lav_pkg::*;

  localparam word_t ONE = word_t'(64'(1) << FRAC_BITS);

  logic busy;
  col_t col;
  mat_t held;

  assign take = !busy || (out_ready && col == COL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= '0;
    end else if (take) begin
      busy <= load_valid;
      col  <= '0;
    end else if (out_ready) begin
      col <= col + 2'd1;
    end
    if (take && load_valid) held <= mat;
  end

  assign out_valid   = busy;
  assign column      = col;
  assign last_column = (col == COL_LAST);
  assign degenerate  = held.degen;

  always_comb begin
    case (col)
      2'd0: begin
        elem_x = held.rgt[0];
        elem_y = held.upv[0];
        elem_z = held.negf[0];
        elem_w = '0;
      end
      2'd1: begin
        elem_x = held.rgt[1];
        elem_y = held.upv[1];
        elem_z = held.negf[1];
        elem_w = '0;
      end
      2'd2: begin
        elem_x = held.rgt[2];
        elem_y = held.upv[2];
        elem_z = held.negf[2];
        elem_w = '0;
      end
      default: begin
        elem_x = held.trn[0];
        elem_y = held.trn[1];
        elem_z = held.trn[2];
        elem_w = ONE;
      end
    endcase
  end

endmodule

// File: rtl/look_at_view_matrix_unit.sv
// Columns: the other three columns follow the first one per cycle while out_ready is high.
// Throughput: the pipeline takes one item per cycle while the output register is idle
//   or its last column is taken; otherwise all stages stall.
// Reset: synchronous, clears all stage valid bits and the busy state of the output register.
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Look-at view matrix in signed fixed point: forward, right and camera up
// vectors, translation, sent as four column results.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lav_pkg::word_t eye_x,
  input  lav_pkg::word_t eye_y,
  input  lav_pkg::word_t eye_z,
  input  lav_pkg::word_t target_x,
  input  lav_pkg::word_t target_y,
  input  lav_pkg::word_t target_z,
  input  lav_pkg::word_t up_x,
  input  lav_pkg::word_t up_y,
  input  lav_pkg::word_t up_z,
  output logic           out_valid,
  input  logic           out_ready,
  output lav_pkg::col_t  column,
  output lav_pkg::word_t elem_x,
  output lav_pkg::word_t elem_y,
  output lav_pkg::word_t elem_z,
  output lav_pkg::word_t elem_w,
  output logic           last_column,
  output logic           degenerate
);
  import lav_pkg::*;

  localparam int S1W = 192;
  localparam int S2W = 193;

  logic adv;
  assign in_ready = adv;

  // difference stage
  logic  a_v;
  wide_t a_d [3];
  word_t a_eye [3];
  word_t a_up [3];

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_valid;
    if (adv) begin
      a_d[0] <= wide_t'(target_x) - wide_t'(eye_x);
      a_d[1] <= wide_t'(target_y) - wide_t'(eye_y);
      a_d[2] <= wide_t'(target_z) - wide_t'(eye_z);
      a_eye  <= '{eye_x, eye_y, eye_z};
      a_up   <= '{up_x, up_y, up_z};
    end
  end

  // forward
  logic           n1_v, n1_zero;
  word_t          f_n [3];
  logic [S1W-1:0] n1_side;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(S1W)) u_norm_fwd (
    .clk, .rst, .adv,
    .in_valid (a_v),
    .vec_in   (a_d),
    .side_in  ({a_eye[0], a_eye[1], a_eye[2], a_up[0], a_up[1], a_up[2]}),
    .out_valid(n1_v),
    .vec_out  (f_n),
    .zero_out (n1_zero),
    .side_out (n1_side)
  );

  word_t n1_eye [3];
  word_t n1_up [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_eye[i] = word_t'(n1_side[S1W-1-32*i -: 32]);
      n1_up[i]  = word_t'(n1_side[95-32*i -: 32]);
    end
  end

  // cross product f x up
  wide_t p_c [6];
  always_comb begin
    p_c[0] = f_n[1] * n1_up[2];
    p_c[1] = f_n[2] * n1_up[1];
    p_c[2] = f_n[2] * n1_up[0];
    p_c[3] = f_n[0] * n1_up[2];
    p_c[4] = f_n[0] * n1_up[1];
    p_c[5] = f_n[1] * n1_up[0];
  end

  logic  c1_v, c1_zero;
  wide_t c1_p [6];
  word_t c1_eye [3];
  word_t c1_f [3];
  logic  c2_v, c2_zero;
  wide_t c2_c [3];
  word_t c2_eye [3];
  word_t c2_f [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
    end else if (adv) begin
      c1_v <= n1_v;
      c2_v <= c1_v;
    end
    if (adv) begin
      c1_p    <= p_c;
      c1_eye  <= n1_eye;
      c1_f    <= f_n;
      c1_zero <= n1_zero;
      for (int i = 0; i < 3; i++) c2_c[i] <= c1_p[2*i] - c1_p[2*i+1];
      c2_eye  <= c1_eye;
      c2_f    <= c1_f;
      c2_zero <= c1_zero;
    end
  end

  // right
  logic           n2_v, n2_zero;
  word_t          r_n [3];
  logic [S2W-1:0] n2_side;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(S2W)) u_norm_rgt (
    .clk, .rst, .adv,
    .in_valid (c2_v),
    .vec_in   (c2_c),
    .side_in  ({c2_eye[0], c2_eye[1], c2_eye[2], c2_f[0], c2_f[1], c2_f[2], c2_zero}),
    .out_valid(n2_v),
    .vec_out  (r_n),
    .zero_out (n2_zero),
    .side_out (n2_side)
  );

  word_t n2_eye [3];
  word_t n2_f [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n2_eye[i] = word_t'(n2_side[S2W-1-32*i -: 32]);
      n2_f[i]   = word_t'(n2_side[96-32*i -: 32]);
    end
  end

  // camera up and translation products
  wide_t p_u [6];
  wide_t p_re [3];
  wide_t p_fe [3];
  always_comb begin
    p_u[0] = r_n[1] * n2_f[2];
    p_u[1] = r_n[2] * n2_f[1];
    p_u[2] = r_n[2] * n2_f[0];
    p_u[3] = r_n[0] * n2_f[2];
    p_u[4] = r_n[0] * n2_f[1];
    p_u[5] = r_n[1] * n2_f[0];
    for (int i = 0; i < 3; i++) begin
      p_re[i] = r_n[i] * n2_eye[i];
      p_fe[i] = n2_f[i] * n2_eye[i];
    end
  end

  logic  u1_v, u2_v, u3_v, u4_v, u5_v, u6_v;
  logic  u1_dg, u2_dg, u3_dg, u4_dg, u5_dg, u6_dg;
  wide_t u1_pu [6];
  wide_t u1_re [3];
  wide_t u1_fe [3];
  word_t u1_eye [3], u2_eye [3], u3_eye [3];
  word_t u1_r [3], u2_r [3], u3_r [3], u4_r [3], u5_r [3], u6_r [3];
  word_t u1_f [3], u2_f [3], u3_f [3], u4_f [3], u5_f [3], u6_f [3];
  wide_t u2_u [3];
  wide_t u2_d0, u2_d2;
  word_t u3_u [3], u4_u [3], u5_u [3], u6_u [3];
  word_t u3_t0, u3_t2, u4_t0, u4_t2, u5_t0, u5_t2, u6_t0, u6_t2;
  wide_t u4_ue [3];
  wide_t u5_d1;
  word_t u6_t1;
  wide_t p_ue [3];

  always_comb begin
    for (int i = 0; i < 3; i++) p_ue[i] = u3_u[i] * u3_eye[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u1_v <= 1'b0;
      u2_v <= 1'b0;
      u3_v <= 1'b0;
      u4_v <= 1'b0;
      u5_v <= 1'b0;
      u6_v <= 1'b0;
    end else if (adv) begin
      u1_v <= n2_v;
      u2_v <= u1_v;
      u3_v <= u2_v;
      u4_v <= u3_v;
      u5_v <= u4_v;
      u6_v <= u5_v;
    end
    if (adv) begin
      u1_pu  <= p_u;
      u1_re  <= p_re;
      u1_fe  <= p_fe;
      u1_eye <= n2_eye;
      u1_r   <= r_n;
      u1_f   <= n2_f;
      u1_dg  <= n2_zero | n2_side[0];

      for (int i = 0; i < 3; i++) u2_u[i] <= u1_pu[2*i] - u1_pu[2*i+1];
      u2_d0  <= u1_re[0] + u1_re[1] + u1_re[2];
      u2_d2  <= u1_fe[0] + u1_fe[1] + u1_fe[2];
      u2_eye <= u1_eye;
      u2_r   <= u1_r;
      u2_f   <= u1_f;
      u2_dg  <= u1_dg;

      for (int i = 0; i < 3; i++) u3_u[i] <= word_t'(round_shift(u2_u[i], FRAC_BITS));
      u3_t0  <= sat32(-round_shift(u2_d0, FRAC_BITS));
      u3_t2  <= sat32(round_shift(u2_d2, FRAC_BITS));
      u3_eye <= u2_eye;
      u3_r   <= u2_r;
      u3_f   <= u2_f;
      u3_dg  <= u2_dg;

      u4_ue <= p_ue;
      u4_u  <= u3_u;
      u4_t0 <= u3_t0;
      u4_t2 <= u3_t2;
      u4_r  <= u3_r;
      u4_f  <= u3_f;
      u4_dg <= u3_dg;

      u5_d1 <= u4_ue[0] + u4_ue[1] + u4_ue[2];
      u5_u  <= u4_u;
      u5_t0 <= u4_t0;
      u5_t2 <= u4_t2;
      u5_r  <= u4_r;
      u5_f  <= u4_f;
      u5_dg <= u4_dg;

      u6_t1 <= sat32(-round_shift(u5_d1, FRAC_BITS));
      u6_u  <= u5_u;
      u6_t0 <= u5_t0;
      u6_t2 <= u5_t2;
      u6_r  <= u5_r;
      u6_f  <= u5_f;
      u6_dg <= u5_dg;
    end
  end

  mat_t mat;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mat.rgt[i]  = u6_r[i];
      mat.upv[i]  = u6_u[i];
      mat.negf[i] = -u6_f[i];
    end
    mat.trn[0] = u6_t0;
    mat.trn[1] = u6_t1;
    mat.trn[2] = u6_t2;
    mat.degen  = u6_dg;
  end

  lav_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk, .rst,
    .load_valid(u6_v),
    .mat,
    .take      (adv),
    .out_valid,
    .out_ready,
    .column,
    .elem_x,
    .elem_y,
    .elem_z,
    .elem_w,
    .last_column,
    .degenerate
  );

  // advance through the four columns one per transfer
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && column != COL_LAST |=>
      out_valid && column == $past(column) + 2'd1)
    else $error("column sequence broken");

  a_deg_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && column != COL_LAST |=> degenerate == $past(degenerate))
    else $error("degenerate flag changed within a matrix");

  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && column == COL_LAST |-> elem_w == word_t'(64'(1) << FRAC_BITS))
    else $error("last column lacks unit w");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline stalled with empty output register");

endmodule

// File: tb/look_at_checker.sv
// ----------------------------------------------------------------------------
// look_at_checker
// Watches both channels of the look-at view matrix unit, predicts the four
// columns of every accepted input transfer and compares each output
// transfer with the oldest predicted column.
// ----------------------------------------------------------------------------
module look_at_checker #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  lav_pkg::word_t eye_x,
  input  lav_pkg::word_t eye_y,
  input  lav_pkg::word_t eye_z,
  input  lav_pkg::word_t target_x,
  input  lav_pkg::word_t target_y,
  input  lav_pkg::word_t target_z,
  input  lav_pkg::word_t up_x,
  input  lav_pkg::word_t up_y,
  input  lav_pkg::word_t up_z,
  input  logic           out_valid,
  input  logic           out_ready,
  input  lav_pkg::col_t  column,
  input  lav_pkg::word_t elem_x,
  input  lav_pkg::word_t elem_y,
  input  lav_pkg::word_t elem_z,
  input  lav_pkg::word_t elem_w,
  input  logic           last_column,
  input  logic           degenerate,
  output int             fail_count,
  output int             pending
);
  import lav_pkg::*;

  typedef struct {
    col_t  idx;
    word_t e[4];
    logic  last;
    logic  degen;
  } view_col_t;

  view_col_t column_queue[$];

  assign pending = column_queue.size();

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // unit vector with FRAC_BITS fraction bits; returns 1 on zero length
  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic longint drop_frac(longint v);
    longint unsigned r;
    r = (abs64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic word_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return word_t'(v);
  endfunction

  task automatic predict_view(input word_t ev[3], input word_t tv[3], input word_t uv[3]);
    longint eye[3], d[3], upw[3], f[3], c[3], r[3], u[3];
    word_t  trn[3];
    bit     degen;
    view_col_t res;
    for (int i = 0; i < 3; i++) begin
      eye[i] = ev[i];
      upw[i] = uv[i];
      d[i] = longint'(tv[i]) - eye[i];
    end
    degen = unit_vec(d, f);
    c[0] = f[1] * upw[2] - f[2] * upw[1];
    c[1] = f[2] * upw[0] - f[0] * upw[2];
    c[2] = f[0] * upw[1] - f[1] * upw[0];
    if (unit_vec(c, r)) degen = 1'b1;
    u[0] = drop_frac(r[1] * f[2] - r[2] * f[1]);
    u[1] = drop_frac(r[2] * f[0] - r[0] * f[2]);
    u[2] = drop_frac(r[0] * f[1] - r[1] * f[0]);
    trn[0] = clamp32(-drop_frac(r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2]));
    trn[1] = clamp32(-drop_frac(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
    trn[2] = clamp32(drop_frac(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]));
    for (int k = 0; k < 4; k++) begin
      res.idx = col_t'(k);
      res.last = (col_t'(k) == COL_LAST);
      res.degen = degen;
      if (k < 3) begin
        res.e[0] = word_t'(r[k]);
        res.e[1] = word_t'(u[k]);
        res.e[2] = word_t'(-f[k]);
        res.e[3] = '0;
      end else begin
        res.e[0] = trn[0];
        res.e[1] = trn[1];
        res.e[2] = trn[2];
        res.e[3] = word_t'(64'd1 << FRAC_BITS);
      end
      column_queue.push_back(res);
    end
  endtask

  task automatic flag(string what, longint unsigned exp_v, longint unsigned act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    view_col_t exp_col;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        predict_view('{eye_x, eye_y, eye_z}, '{target_x, target_y, target_z},
                     '{up_x, up_y, up_z});
      if (out_valid && out_ready) begin
        if (column_queue.size() == 0) begin
          $display("%0t: unexpected column transfer, actual column %0d", $time, column);
          fail_count++;
        end else begin
          exp_col = column_queue.pop_front();
          if (column !== exp_col.idx) flag("column", exp_col.idx, column);
          if (elem_x !== exp_col.e[0]) flag("elem_x", exp_col.e[0], elem_x);
          if (elem_y !== exp_col.e[1]) flag("elem_y", exp_col.e[1], elem_y);
          if (elem_z !== exp_col.e[2]) flag("elem_z", exp_col.e[2], elem_z);
          if (elem_w !== exp_col.e[3]) flag("elem_w", exp_col.e[3], elem_w);
          if (last_column !== exp_col.last) flag("last_column", exp_col.last, last_column);
          if (degenerate !== exp_col.degen) flag("degenerate", exp_col.degen, degenerate);
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives eye, target and up vectors into the look-at view matrix unit with
// random idling on both channels; the checker predicts and compares the
// four matrix columns of each transfer.
// ----------------------------------------------------------------------------
module testbench;
  import lav_pkg::*;

  localparam int NUM_RANDOM = 390;
  localparam int DRAIN_CYCLES = 200;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t eye_x = '0, eye_y = '0, eye_z = '0;
  word_t target_x = '0, target_y = '0, target_z = '0;
  word_t up_x = '0, up_y = '0, up_z = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  col_t  column;
  word_t elem_x, elem_y, elem_z, elem_w;
  logic  last_column, degenerate;
  int    fail_count, pending;
  int    send_idle = 24;
  int    recv_idle = 59;

  always #5 clk = ~clk;

  look_at_view_matrix_unit u_top (.*);

  look_at_checker u_check (.*);

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_view(word_t ex, word_t ey, word_t ez, word_t tx, word_t ty, word_t tz,
                           word_t ux, word_t uy, word_t uz);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    target_x <= tx; target_y <= ty; target_z <= tz;
    up_x <= ux; up_y <= uy; up_z <= uz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly moderate coordinates, sometimes the full word range
  function automatic word_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1:    return word_t'($urandom);
      2:       return word_t'($urandom_range(0, 7)) << 16;
      default: return word_t'(int'($urandom_range(0, 32'h01ffffff)) - 32'h01000000);
    endcase
  endfunction

  initial begin
    word_t p, q, a, b;
    int    n, kind;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // camera on +z looking at the origin
    send_view(0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0);
    // eye equal to target
    send_view(32'h0001_0000, 2, 3, 32'h0001_0000, 2, 3, 0, 32'h0001_0000, 0);
    // forward parallel to up
    send_view(0, 0, 0, 0, 32'h0003_0000, 0, 0, 32'h0001_0000, 0);
    // zero up vector
    send_view(1, 2, 3, 7, -5, 9, 0, 0, 0);
    // extreme coordinates, largest differences
    send_view(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_view(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
    // translation saturation: far eye along the right axis
    send_view(32'h7fffffff, 0, 0, 32'h7fffffff, 0, -32'h0001_0000, 0, 32'h0001_0000, 0);
    send_view(32'h80000000, 0, 0, 32'h80000000, 0, 32'h0001_0000, 0, 32'h0001_0000, 0);
    send_view(0, 32'h7fffffff, 32'h7fffffff, 1, 32'h7ffffff0, 0, 32'h0001_0000, 0, 0);
    // tiny vectors
    send_view(0, 0, 0, 1, 0, 0, 0, 0, 1);
    send_view(-1, -1, -1, 0, 0, 0, -1, 1, 0);
    send_view(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0,
              32'hffffffff, 32'hffffffff, 32'h7fffffff);

    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        send_idle = 59;
        recv_idle = 24;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      kind = $urandom_range(0, 19);
      p = pick_coord(); q = pick_coord(); a = pick_coord(); b = pick_coord();
      if (kind == 0)       // eye equal to target
        send_view(p, q, a, p, q, a, pick_coord(), pick_coord(), pick_coord());
      else if (kind == 1)  // up parallel to forward
        send_view(0, 0, 0, p >>> 4, q >>> 4, a >>> 4, p >>> 3, q >>> 3, a >>> 3);
      else if (kind == 2)
        send_view(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                  word_t'($urandom), word_t'($urandom), word_t'($urandom),
                  word_t'($urandom), word_t'($urandom), word_t'($urandom));
      else
        send_view(p, q, a, b, pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
